// ===== hdl/gre_source_address_rewriter_defines.svh =====
// Assertion macros shared by the checker of the GRE source address rewriter.
`ifndef GRE_SOURCE_ADDRESS_REWRITER_DEFINES_SVH
`define GRE_SOURCE_ADDRESS_REWRITER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define GSAR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gsar assertion failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define GSAR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gsar assertion failed");

`endif

// ===== hdl/gsar_pkg.sv =====
// Types and constants shared by the GRE source address rewriter modules.
`default_nettype none

package gsar_pkg;

  // Number of held header bytes: Ethernet header plus a 20-byte IPv4 header.
  localparam logic [5:0] HdrBytes = 6'd34;

  // Byte positions inside the held header.
  localparam logic [5:0] PosEtypeHi = 6'd12;
  localparam logic [5:0] PosEtypeLo = 6'd13;
  localparam logic [5:0] PosIpFirst = 6'd14;
  localparam logic [5:0] PosProto   = 6'd23;
  localparam logic [5:0] PosCsumHi  = 6'd24;
  localparam logic [5:0] PosCsumLo  = 6'd25;
  localparam logic [5:0] PosSrc0    = 6'd26;
  localparam logic [5:0] PosSrc1    = 6'd27;
  localparam logic [5:0] PosSrc2    = 6'd28;
  localparam logic [5:0] PosSrc3    = 6'd29;
  localparam logic [5:0] PosDst0    = 6'd30;
  localparam logic [5:0] PosIpLast  = 6'd33;

  localparam logic [15:0] EtypeIpv6 = 16'h86DD;
  localparam logic [7:0]  ProtoGre  = 8'd47;

  // Configuration register indexes.
  localparam logic CfgMatchAddr = 1'b0;
  localparam logic CfgReplAddr  = 1'b1;

  typedef enum logic [1:0] {
    StFill,
    StDecide,
    StEmit,
    StPass
  } gsar_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic hdr_wr;   // store the accepted input item in the header store
    logic calc;     // take the rewrite decision and the new checksum
    logic emit_ld;  // load the next held byte into the output register
    logic pass_ld;  // load the accepted input item into the output register
  } gsar_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pos_last;  // the next header byte completes the header
    logic emit_end;  // the held byte being loaded is the final one
    logic out_free;  // the output register can take an item this cycle
  } gsar_sts_t;

endpackage

`default_nettype wire

// ===== hdl/gsar_ctrl.sv =====
// Controller state machine: header fill, decision, emission and pass-through.
`default_nettype none

module gsar_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_tvalid_i,
  input  logic               s_tlast_i,
  input  gsar_pkg::gsar_sts_t sts_i,
  output logic               s_tready_o,
  output gsar_pkg::gsar_cmd_t cmd_o
);

  gsar_pkg::gsar_state_e state_q, state_d;
  logic frame_last_q, frame_last_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= gsar_pkg::StFill;
      frame_last_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      frame_last_q <= frame_last_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    frame_last_d = frame_last_q;
    s_tready_o   = 1'b0;
    cmd_o        = '0;
    unique case (state_q)
      gsar_pkg::StFill: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          cmd_o.hdr_wr = 1'b1;
          frame_last_d = s_tlast_i;
          if (s_tlast_i || sts_i.pos_last) begin
            state_d = gsar_pkg::StDecide;
          end
        end
      end
      gsar_pkg::StDecide: begin
        cmd_o.calc = 1'b1;
        state_d    = gsar_pkg::StEmit;
      end
      gsar_pkg::StEmit: begin
        if (sts_i.out_free) begin
          cmd_o.emit_ld = 1'b1;
          if (sts_i.emit_end) begin
            state_d = frame_last_q ? gsar_pkg::StFill : gsar_pkg::StPass;
          end
        end
      end
      gsar_pkg::StPass: begin
        s_tready_o = sts_i.out_free;
        if (s_tvalid_i && sts_i.out_free) begin
          cmd_o.pass_ld = 1'b1;
          if (s_tlast_i) begin
            state_d = gsar_pkg::StFill;
          end
        end
      end
      default: begin
        state_d = gsar_pkg::StFill;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/gsar_dp.sv =====
// Datapath: header store, field capture, checksum, output register.
`default_nettype none

module gsar_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  gsar_pkg::gsar_cmd_t cmd_i,
  output gsar_pkg::gsar_sts_t sts_o,
  input  logic [7:0]          s_tdata_i,
  input  logic                s_tlast_i,
  input  logic                m_tready_i,
  input  logic                cfg_we_i,
  input  logic                cfg_addr_i,
  input  logic [31:0]         cfg_data_i,
  output logic                m_tvalid_o,
  output logic [7:0]          m_tdata_o,
  output logic                m_tlast_o,
  output logic                m_tuser_o
);

  logic [7:0]  hdr_mem [int'(gsar_pkg::HdrBytes)];
  logic [5:0]  pos_q, ptr_q;
  logic [5:0]  rd_addr;
  logic [7:0]  rd_data_q;
  logic [19:0] acc_q;
  logic [15:0] etype_q;
  logic [7:0]  proto_q;
  logic [31:0] src_q;
  logic [31:0] match_q, repl_q;
  logic [15:0] csum_q;
  logic        rewritten_q;
  logic        frame_last_q;
  logic        out_vld_q;
  logic [7:0]  out_data_q;
  logic        out_last_q;
  logic        out_user_q;

  logic        in_sum;
  logic [19:0] sum;
  logic [16:0] fold1;
  logic [15:0] fold2;
  logic        rewrite;
  logic [7:0]  emit_byte;

  assign sts_o.pos_last = (pos_q == gsar_pkg::PosIpLast);
  assign sts_o.emit_end = (ptr_q == pos_q - 6'd1);
  assign sts_o.out_free = !out_vld_q || m_tready_i;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= '0;
      repl_q  <= '0;
    end else if (cfg_we_i) begin
      if (cfg_addr_i == gsar_pkg::CfgMatchAddr) begin
        match_q <= cfg_data_i;
      end else begin
        repl_q <= cfg_data_i;
      end
    end
  end

  // Header store: one write port fed by the input, one registered read port.
  assign rd_addr = cmd_i.emit_ld ? ptr_q + 6'd1 : ptr_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.hdr_wr) begin
      hdr_mem[pos_q] <= s_tdata_i;
    end
    if (rd_addr < gsar_pkg::HdrBytes) begin
      rd_data_q <= hdr_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      ptr_q        <= '0;
      frame_last_q <= 1'b0;
      rewritten_q  <= 1'b0;
    end else begin
      if (cmd_i.hdr_wr) begin
        pos_q        <= pos_q + 6'd1;
        frame_last_q <= s_tlast_i;
      end
      if (cmd_i.emit_ld) begin
        if (sts_o.emit_end) begin
          pos_q <= '0;
          ptr_q <= '0;
        end else begin
          ptr_q <= ptr_q + 6'd1;
        end
      end
      if (cmd_i.calc) begin
        rewritten_q <= rewrite;
      end
    end
  end

  // The header words other than checksum and source address are summed as
  // they arrive; the replacement address is added at decision time.
  assign in_sum = (pos_q >= gsar_pkg::PosIpFirst && pos_q <= gsar_pkg::PosProto)
               || (pos_q >= gsar_pkg::PosDst0 && pos_q <= gsar_pkg::PosIpLast);

  always_ff @(posedge clk_i) begin
    if (cmd_i.hdr_wr) begin
      if (pos_q == 6'd0) begin
        acc_q <= '0;
      end else if (in_sum) begin
        acc_q <= pos_q[0] ? acc_q + {12'd0, s_tdata_i}
                          : acc_q + {4'd0, s_tdata_i, 8'd0};
      end
      unique case (pos_q)
        gsar_pkg::PosEtypeHi: etype_q[15:8] <= s_tdata_i;
        gsar_pkg::PosEtypeLo: etype_q[7:0]  <= s_tdata_i;
        gsar_pkg::PosProto:   proto_q       <= s_tdata_i;
        gsar_pkg::PosSrc0:    src_q[31:24]  <= s_tdata_i;
        gsar_pkg::PosSrc1:    src_q[23:16]  <= s_tdata_i;
        gsar_pkg::PosSrc2:    src_q[15:8]   <= s_tdata_i;
        gsar_pkg::PosSrc3:    src_q[7:0]    <= s_tdata_i;
        default: ;
      endcase
    end
    if (cmd_i.calc) begin
      csum_q <= ~fold2;
    end
  end

  assign sum   = acc_q + {4'd0, repl_q[31:16]} + {4'd0, repl_q[15:0]};
  assign fold1 = {1'b0, sum[15:0]} + {13'd0, sum[19:16]};
  assign fold2 = fold1[15:0] + {15'd0, fold1[16]};

  assign rewrite = (pos_q == gsar_pkg::HdrBytes) && (etype_q != gsar_pkg::EtypeIpv6)
                && (proto_q == gsar_pkg::ProtoGre) && (src_q == match_q)
                && (repl_q != 32'd0);

  always_comb begin
    emit_byte = rd_data_q;
    if (rewritten_q) begin
      unique case (ptr_q)
        gsar_pkg::PosCsumHi: emit_byte = csum_q[15:8];
        gsar_pkg::PosCsumLo: emit_byte = csum_q[7:0];
        gsar_pkg::PosSrc0:   emit_byte = repl_q[31:24];
        gsar_pkg::PosSrc1:   emit_byte = repl_q[23:16];
        gsar_pkg::PosSrc2:   emit_byte = repl_q[15:8];
        gsar_pkg::PosSrc3:   emit_byte = repl_q[7:0];
        default:             emit_byte = rd_data_q;
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.emit_ld || cmd_i.pass_ld) begin
      out_vld_q <= 1'b1;
    end else if (m_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_ld) begin
      out_data_q <= emit_byte;
      out_last_q <= frame_last_q && sts_o.emit_end;
      out_user_q <= rewritten_q;
    end else if (cmd_i.pass_ld) begin
      out_data_q <= s_tdata_i;
      out_last_q <= s_tlast_i;
      out_user_q <= rewritten_q;
    end
  end

  assign m_tvalid_o = out_vld_q;
  assign m_tdata_o  = out_data_q;
  assign m_tlast_o  = out_last_q;
  assign m_tuser_o  = out_user_q;

endmodule

`default_nettype wire

// ===== hdl/gre_source_address_rewriter.sv =====
// Top level of the GRE source address rewriter.
//
//   Channel   Direction  Handshake                     Payload
//   s_axis    in         s_axis_tvalid/s_axis_tready   tdata = in_byte, tlast = in_last
//   m_axis    out        m_axis_tvalid/m_axis_tready   tdata = out_byte, tlast = out_last,
//                                                      tuser = was_rewritten
//   cfg       in         cfg_we_i                      cfg_addr_i, cfg_data_i
//
// The first 34 bytes of a frame are taken one per cycle into the header store.
// A decision state follows; then the held bytes leave one per cycle while the output
// is not stalled, paced by the single read port of the header store and the output register.
// Later bytes pass through the output register at one per cycle while the output is not stalled.
// The input is held off during the decision and emission; reset is asynchronous.
`default_nettype none

module gre_source_address_rewriter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic        m_axis_tlast,
  output logic        m_axis_tuser,   // [0] was_rewritten
  input  logic        cfg_we_i,
  input  logic        cfg_addr_i,
  input  logic [31:0] cfg_data_i
);

  gsar_pkg::gsar_cmd_t cmd;
  gsar_pkg::gsar_sts_t sts;

  gsar_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tlast_i  (s_axis_tlast),
    .sts_i      (sts),
    .s_tready_o (s_axis_tready),
    .cmd_o      (cmd)
  );

  gsar_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .s_tdata_i  (s_axis_tdata),
    .s_tlast_i  (s_axis_tlast),
    .m_tready_i (m_axis_tready),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_data_i (cfg_data_i),
    .m_tvalid_o (m_axis_tvalid),
    .m_tdata_o  (m_axis_tdata),
    .m_tlast_o  (m_axis_tlast),
    .m_tuser_o  (m_axis_tuser)
  );

endmodule

`default_nettype wire

// ===== hdl/gsar_checker.sv =====
// Port-level checker for the GRE source address rewriter and its bind.
`default_nettype none

`include "gre_source_address_rewriter_defines.svh"

module gsar_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata,
  input logic        m_axis_tlast,
  input logic        m_axis_tuser
);

  logic       s_fire, m_fire;
  logic [6:0] pend_q;
  logic       mid_q;
  logic       user_q;

  assign s_fire = s_axis_tvalid && s_axis_tready;
  assign m_fire = m_axis_tvalid && m_axis_tready;

  // Items taken in but not yet delivered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      mid_q  <= 1'b0;
      user_q <= 1'b0;
    end else begin
      pend_q <= pend_q + {6'd0, s_fire} - {6'd0, m_fire};
      if (m_fire) begin
        mid_q  <= !m_axis_tlast;
        user_q <= m_axis_tuser;
      end
    end
  end

  `GSAR_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
                    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
                    && $stable(m_axis_tuser))
  `GSAR_ASSERT_IMPL(a_no_invented_item, clk_i, rst_ni, m_fire, pend_q != 7'd0)
  `GSAR_ASSERT_IMPL(a_user_per_frame, clk_i, rst_ni, m_axis_tvalid && mid_q,
                    m_axis_tuser == user_q)

endmodule

bind gre_source_address_rewriter gsar_checker u_gsar_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// ===== bench/gre_source_address_rewriter_tb.sv =====
// Self-checking testbench for the GRE source address rewriter, with frame traffic and a checker.
`timescale 1ns / 100ps

module gre_source_address_rewriter_tb;

  localparam int SettleCycles = 48;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       rewritten;
  } egress_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // [7:0] in_byte
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;        // [7:0] out_byte
  logic        m_axis_tlast;
  logic        m_axis_tuser;        // [0] was_rewritten
  logic        cfg_we_i = 1'b0;
  logic        cfg_addr_i = gsar_pkg::CfgMatchAddr;
  logic [31:0] cfg_data_i = '0;

  gre_source_address_rewriter uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  // Predictor state: the header bytes held so far and the current register values.
  logic [7:0]   held_hdr [0:gsar_pkg::HdrBytes-1];
  logic [5:0]   held_cnt = '0;
  logic         frame_rw = 1'b0;
  logic [31:0]  match_addr = '0;
  logic [31:0]  new_addr = '0;
  egress_item_t egress_q [$];

  int         err_count = 0;
  int         bytes_sent = 0;
  bit         no_idle = 1'b0;
  logic [7:0] frame_bytes [$];

  function automatic logic [15:0] ipv4_header_checksum();
    logic [31:0] acc;
    acc = '0;
    for (int i = int'(gsar_pkg::PosIpFirst); i <= int'(gsar_pkg::PosIpLast); i += 2) begin
      if (i != int'(gsar_pkg::PosCsumHi)) acc += {16'h0, held_hdr[i], held_hdr[i+1]};
    end
    // The carry is folded twice so that a carry out of the first fold is kept.
    acc = {16'h0, acc[15:0]} + {16'h0, acc[31:16]};
    acc = {16'h0, acc[15:0]} + {16'h0, acc[31:16]};
    return ~acc[15:0];
  endfunction

  function automatic logic apply_source_rewrite();
    logic [15:0] etype;
    logic [31:0] src;
    logic [15:0] csum;
    etype = {held_hdr[gsar_pkg::PosEtypeHi], held_hdr[gsar_pkg::PosEtypeLo]};
    src = {held_hdr[gsar_pkg::PosSrc0], held_hdr[gsar_pkg::PosSrc1],
           held_hdr[gsar_pkg::PosSrc2], held_hdr[gsar_pkg::PosSrc3]};
    if (etype == gsar_pkg::EtypeIpv6 || held_hdr[gsar_pkg::PosProto] != gsar_pkg::ProtoGre ||
        src != match_addr || new_addr == '0) begin
      return 1'b0;
    end
    {held_hdr[gsar_pkg::PosSrc0], held_hdr[gsar_pkg::PosSrc1],
     held_hdr[gsar_pkg::PosSrc2], held_hdr[gsar_pkg::PosSrc3]} = new_addr;
    csum = ipv4_header_checksum();
    {held_hdr[gsar_pkg::PosCsumHi], held_hdr[gsar_pkg::PosCsumLo]} = csum;
    return 1'b1;
  endfunction

  function automatic void queue_held_bytes(int count, logic last, logic rw);
    egress_item_t e;
    for (int k = 0; k < count; k++) begin
      e.data = held_hdr[k];
      e.last = last && (k == count - 1);
      e.rewritten = rw;
      egress_q.push_back(e);
    end
  endfunction

  function automatic void track_ingress_byte(logic [7:0] b, logic last);
    egress_item_t e;
    if (held_cnt >= gsar_pkg::HdrBytes) begin
      e.data = b;
      e.last = last;
      e.rewritten = frame_rw;
      egress_q.push_back(e);
      if (last) begin
        held_cnt = '0;
        frame_rw = 1'b0;
      end
      return;
    end
    held_hdr[held_cnt] = b;
    held_cnt++;
    if (held_cnt == gsar_pkg::HdrBytes) begin
      frame_rw = apply_source_rewrite();
      queue_held_bytes(int'(gsar_pkg::HdrBytes), last, frame_rw);
      if (last) begin
        held_cnt = '0;
        frame_rw = 1'b0;
      end
    end else if (last) begin
      // A frame shorter than the header leaves unchanged at its last byte.
      queue_held_bytes(int'(held_cnt), 1'b1, 1'b0);
      held_cnt = '0;
      frame_rw = 1'b0;
    end
  endfunction

  function automatic void note_mismatch(string what, egress_item_t e, logic [7:0] b,
                                        logic last, logic rw);
    err_count++;
    if (err_count <= 10) begin
      $display("%0t: %s: expected %02h last %0b rw %0b, got %02h last %0b rw %0b",
               $realtime, what, e.data, e.last, e.rewritten, b, last, rw);
    end
  endfunction

  function automatic void check_egress(logic [7:0] b, logic last, logic rw);
    egress_item_t e;
    e = '0;
    if (egress_q.size() == 0) begin
      note_mismatch("output item with nothing expected", e, b, last, rw);
      return;
    end
    e = egress_q.pop_front();
    if (e.data !== b || e.last !== last || e.rewritten !== rw) begin
      note_mismatch("output item mismatch", e, b, last, rw);
    end
  endfunction

  // Everything is sampled at the rising edge, before the block's own updates land.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) begin
        if (cfg_addr_i == gsar_pkg::CfgMatchAddr) match_addr = cfg_data_i;
        else new_addr = cfg_data_i;
      end
      if (s_axis_tvalid && s_axis_tready) track_ingress_byte(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) check_egress(m_axis_tdata, m_axis_tlast, m_axis_tuser);
    end
  end

  // The receiver draws a random stall, possibly none, after every item it takes.
  int sink_wait = 0;
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) sink_wait = no_idle ? 0 : $urandom_range(0, 11);
    else if (sink_wait > 0) sink_wait--;
    m_axis_tready <= (sink_wait == 0);
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tlast <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_sent++;
  endtask

  task automatic send_frame();
    for (int k = 0; k < frame_bytes.size(); k++) begin
      send_byte(frame_bytes[k], k == frame_bytes.size() - 1);
    end
  endtask

  task automatic wait_output_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (egress_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_addresses(input logic [31:0] match_val, input logic [31:0] repl_val);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= gsar_pkg::CfgMatchAddr;
    cfg_data_i <= match_val;
    @(posedge clk_i);
    cfg_addr_i <= gsar_pkg::CfgReplAddr;
    cfg_data_i <= repl_val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Fills frame_bytes; header fields are placed only when the frame holds a full header.
  task automatic build_frame(input logic [15:0] etype, input logic [7:0] proto,
                             input logic [31:0] src, input logic [7:0] fill,
                             input bit rand_fill, input int total_len);
    frame_bytes.delete();
    for (int i = 0; i < total_len; i++) begin
      frame_bytes.push_back(rand_fill ? 8'($urandom) : fill);
    end
    if (total_len >= gsar_pkg::HdrBytes) begin
      frame_bytes[gsar_pkg::PosEtypeHi] = etype[15:8];
      frame_bytes[gsar_pkg::PosEtypeLo] = etype[7:0];
      frame_bytes[gsar_pkg::PosProto] = proto;
      frame_bytes[gsar_pkg::PosSrc0] = src[31:24];
      frame_bytes[gsar_pkg::PosSrc1] = src[23:16];
      frame_bytes[gsar_pkg::PosSrc2] = src[15:8];
      frame_bytes[gsar_pkg::PosSrc3] = src[7:0];
    end
  endtask

  task automatic test_registers_at_reset();
    // Match and replacement are both zero: the source matches but rewriting is off.
    build_frame(16'h0800, gsar_pkg::ProtoGre, 32'h0, 8'h00, 1'b1, int'(gsar_pkg::HdrBytes));
    send_frame();
    wait_output_drained();
  endtask

  task automatic test_rewrite_cases();
    logic [31:0] addr;
    addr = 32'hC0A8_0001;
    set_addresses(addr, 32'h0A00_0001);
    build_frame(16'h0800, gsar_pkg::ProtoGre, addr, 8'h00, 1'b1, 35);
    send_frame();
    build_frame(gsar_pkg::EtypeIpv6, gsar_pkg::ProtoGre, addr, 8'h00, 1'b1,
                int'(gsar_pkg::HdrBytes));
    send_frame();
    wait_output_drained();
    // All-ones fill and addresses drive the checksum sum to a large carry that must be folded.
    set_addresses(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    build_frame(16'h0800, gsar_pkg::ProtoGre, 32'hFFFF_FFFF, 8'hFF, 1'b0,
                int'(gsar_pkg::HdrBytes));
    send_frame();
    wait_output_drained();
  endtask

  task automatic test_short_frames();
    set_addresses(32'h0A0B_0C0D, 32'h0102_0304);
    build_frame(16'h0, 8'h0, 32'h0, 8'h00, 1'b1, 1);
    send_frame();
    send_frame();
    build_frame(16'h0, 8'h0, 32'h0, 8'h00, 1'b1, 2);
    send_frame();
    build_frame(16'h0, 8'h0, 32'h0, 8'h00, 1'b1, int'(gsar_pkg::HdrBytes) - 1);
    send_frame();
    wait_output_drained();
  endtask

  task automatic test_random_traffic();
    logic [31:0] m;
    logic [31:0] r;
    logic [31:0] src;
    logic [15:0] etype;
    logic [7:0]  proto;
    int          budget;
    m = $urandom;
    r = $urandom | 32'h1;
    set_addresses(m, r);
    budget = bytes_sent + 30;
    while (bytes_sent < budget) begin
      no_idle = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 9) < 7) begin
        // A well-formed GRE-over-IPv4 header with random content, mostly matching.
        case ($urandom_range(0, 5))
          0: etype = gsar_pkg::EtypeIpv6;
          1: etype = 16'($urandom);
          default: etype = 16'h0800;
        endcase
        proto = ($urandom_range(0, 5) == 0) ? 8'($urandom) : gsar_pkg::ProtoGre;
        src = ($urandom_range(0, 4) == 0) ? m ^ (32'h1 << $urandom_range(0, 31)) : m;
        build_frame(etype, proto, src, 8'h00, 1'b1,
                    $urandom_range(int'(gsar_pkg::HdrBytes), 44));
      end else begin
        build_frame(16'($urandom), 8'($urandom), $urandom, 8'h00, 1'b1,
                    $urandom_range(1, 40));
      end
      send_frame();
      if ($urandom_range(0, 5) == 0) wait_output_drained();
    end
    no_idle = 1'b0;
    wait_output_drained();
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_registers_at_reset();
    test_rewrite_cases();
    test_short_frames();
    test_random_traffic();
    wait_output_drained();
    if (err_count == 0) begin
      $display("gre_source_address_rewriter verification clean");
    end else begin
      $display("gre_source_address_rewriter verification failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("gre_source_address_rewriter verification failed");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/gsar_pkg.sv
hdl/gsar_ctrl.sv
hdl/gsar_dp.sv
hdl/gre_source_address_rewriter.sv
hdl/gsar_checker.sv
bench/gre_source_address_rewriter_tb.sv
